FILE: sv/swm_pkg.sv
// swm_pkg: shared types and constants for the sliding window median block
// no dependencies; used by the channel interfaces, sliding_window_median and the testbench
`default_nettype none

package swm_pkg;

    localparam int STAMP_W = 32;

    typedef logic [STAMP_W-1:0] stamp_t;

endpackage : swm_pkg

`default_nettype wire

FILE: sv/swm_if.sv
// swm_if: valid/ready channel interfaces for stamps in and medians out
// depends on swm_pkg for the stamp type
`default_nettype none

interface swm_stamp_if;
    logic            valid;
    logic            ready;
    swm_pkg::stamp_t stamp;

    modport source (output valid, output stamp, input ready);
    modport sink   (input valid, input stamp, output ready);
endinterface : swm_stamp_if

interface swm_median_if;
    logic            valid;
    logic            ready;
    swm_pkg::stamp_t median_stamp;

    modport source (output valid, output median_stamp, input ready);
    modport sink   (input valid, input median_stamp, output ready);
endinterface : swm_median_if

`default_nettype wire

FILE: sv/swm_ram.sv
// swm_ram: simple dual port synchronous ram, one write and one registered read
// no package dependencies
`default_nettype none

module swm_ram #(
    parameter int DEPTH = 11,
    parameter int AW    = 4,
    parameter int DW    = 36
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read: data is valid in the cycle after the address
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule : swm_ram

`default_nettype wire

FILE: sv/sliding_window_median.sv
// sliding_window_median: running median over the last WINDOW stamps
// depends on swm_pkg, swm_if (channel interfaces) and swm_ram
//
//   channel     dir   payload              handshake
//   stamp_ch    in    stamp[31:0]          valid/ready, taken when both high
//   median_ch   out   median_stamp[31:0]   valid/ready, taken when both high
//
// one item in, one median out; items are processed one at a time
// each item passes through the accept state, a fetch of the evicted stamp when
// the window is full, a sweep over every stored stamp and a write-back of the
// new entry, in that order, as the single read port of the history ram demands
// each ram entry holds a stamp and its rank in the window; ranks are updated
// in one read-modify-write sweep, and the entry whose new rank is count/2 is
// the median (the new stamp itself if no stored one matches)
// reset (rst_n, async low) empties the window; ram contents need no clearing
// the finished median sits in an output register; a new item is accepted
// while it waits, and the next pass holds at its end until the register frees
`default_nettype none

module sliding_window_median #(
    parameter int WINDOW = 11
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    swm_stamp_if.sink    stamp_ch,
    swm_median_if.source median_ch
);

    localparam int CW = $clog2(WINDOW + 1);
    localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int DW = CW + swm_pkg::STAMP_W;

    localparam logic [CW-1:0] WIN_CNT  = CW'(WINDOW);
    localparam logic [CW-1:0] WIN_LAST = CW'(WINDOW - 1);

    // sequencer state codes
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_OLD    = 3'd1;  // evicted stamp arriving from ram
    localparam logic [2:0] ST_SWEEP  = 3'd2;  // rank update pass
    localparam logic [2:0] ST_FINISH = 3'd3;  // write new entry, advance ring
    localparam logic [2:0] ST_WAIT   = 3'd4;  // median waits for output register

    logic [2:0]      state_reg, state_next;
    logic [CW-1:0]   fill_reg, fill_next;
    logic [CW-1:0]   oldest_reg, oldest_next;
    logic [CW-1:0]   k_reg, k_next;
    logic [CW-1:0]   rank_x_reg, rank_x_next;
    swm_pkg::stamp_t x_reg, x_next;
    swm_pkg::stamp_t y_reg, y_next;
    swm_pkg::stamp_t med_reg, med_next;
    logic            found_reg, found_next;
    logic            out_valid_reg, out_valid_next;
    swm_pkg::stamp_t out_data_reg, out_data_next;

    // ram ports
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [DW-1:0]   wr_data;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    logic [DW-1:0]   rd_data;

    // sweep datapath
    swm_pkg::stamp_t rd_value;
    logic [CW-1:0]   rd_rank;
    logic            full;
    logic            skip;
    logic            dec;
    logic            inc;
    logic [CW-1:0]   rank_new;
    logic [CW-1:0]   n_new;
    logic [CW-1:0]   half;
    logic            out_free;
    logic            accept;
    logic            last;

    assign full     = (fill_reg == WIN_CNT);
    assign rd_value = rd_data[swm_pkg::STAMP_W-1:0];
    assign rd_rank  = rd_data[DW-1:swm_pkg::STAMP_W];
    assign skip     = full && (k_reg[AW-1:0] == oldest_reg[AW-1:0]);
    // the evicted stamp is oldest, so it sorts first among equal values
    assign dec      = full && (y_reg <= rd_value);
    // the new stamp is newest, so it sorts last among equal values
    assign inc      = (x_reg < rd_value);
    assign rank_new = rd_rank - CW'(dec) + CW'(inc);
    assign n_new    = full ? WIN_CNT : (fill_reg + CW'(1));
    assign half     = n_new >> 1;
    assign last     = (k_reg == (fill_reg - CW'(1)));

    assign out_free       = !out_valid_reg || median_ch.ready;
    assign stamp_ch.ready = (state_reg == ST_IDLE);
    assign accept         = stamp_ch.valid && stamp_ch.ready;

    assign median_ch.valid        = out_valid_reg;
    assign median_ch.median_stamp = out_data_reg;

    // read address: evicted slot first when full, then slots in order
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                rd_en   = accept && (fill_reg != '0);
                rd_addr = full ? oldest_reg[AW-1:0] : '0;
            end
            ST_OLD:
            begin
                rd_en   = 1'b1;
                rd_addr = '0;
            end
            ST_SWEEP:
            begin
                rd_en   = !last;
                rd_addr = k_reg[AW-1:0] + AW'(1);
            end
            default:
            begin
                rd_en   = 1'b0;
                rd_addr = '0;
            end
        endcase
    end

    // write port: rank write-back during the sweep, new entry at the end;
    // reads run ahead of write-backs by one slot, so they never collide
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = k_reg[AW-1:0];
        wr_data = {rank_new, rd_value};
        if (state_reg == ST_SWEEP)
        begin
            wr_en = !skip;
        end
        else if (state_reg == ST_FINISH)
        begin
            wr_en   = 1'b1;
            wr_addr = oldest_reg[AW-1:0];
            wr_data = {rank_x_reg, x_reg};
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        oldest_next    = oldest_reg;
        k_next         = k_reg;
        rank_x_next    = rank_x_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        med_next       = med_reg;
        found_next     = found_reg;
        out_valid_next = out_free ? 1'b0 : out_valid_reg;
        out_data_next  = out_data_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    x_next      = stamp_ch.stamp;
                    rank_x_next = '0;
                    found_next  = 1'b0;
                    k_next      = '0;
                    if (fill_reg == '0)
                    begin
                        state_next = ST_FINISH;
                    end
                    else if (full)
                    begin
                        state_next = ST_OLD;
                    end
                    else
                    begin
                        state_next = ST_SWEEP;
                    end
                end
            end
            ST_OLD:
            begin
                y_next     = rd_value;
                state_next = ST_SWEEP;
            end
            ST_SWEEP:
            begin
                if (!skip)
                begin
                    rank_x_next = rank_x_reg + CW'(rd_value <= x_reg);
                    if (rank_new == half)
                    begin
                        found_next = 1'b1;
                        med_next   = rd_value;
                    end
                end
                k_next = k_reg + CW'(1);
                if (last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                oldest_next = (oldest_reg == WIN_LAST) ? '0 : (oldest_reg + CW'(1));
                fill_next   = full ? fill_reg : (fill_reg + CW'(1));
                // no stored stamp landed on the middle rank: the new one did
                if (!found_reg)
                begin
                    med_next = x_reg;
                end
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = found_reg ? med_reg : x_reg;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = med_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            oldest_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            oldest_reg    <= oldest_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload and per-pass working registers
    always_ff @(posedge clk)
    begin
        k_reg        <= k_next;
        rank_x_reg   <= rank_x_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        med_reg      <= med_next;
        found_reg    <= found_next;
        out_data_reg <= out_data_next;
    end

    swm_ram #(
        .DEPTH (WINDOW),
        .AW    (AW),
        .DW    (DW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // fill count never passes the window size
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= WIN_CNT)
        else $error("fill count beyond window");

    // until the ring wraps, the write slot tracks the fill count
    a_ring_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg != WIN_CNT) |-> (oldest_reg == fill_reg))
        else $error("write slot out of step with fill count");

    // the sweep only visits written slots
    a_sweep_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP) |-> (k_reg < fill_reg))
        else $error("sweep beyond stored stamps");

    // each finished pass grows the window by one until it saturates
    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) |=>
            ((fill_reg == WIN_CNT) &&
             (($past(fill_reg) == WIN_CNT) || ($past(fill_reg) == WIN_LAST))) ||
            (fill_reg == $past(fill_reg) + CW'(1)))
        else $error("fill count did not advance");

    // no item is taken while a pass is still running
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP || state_reg == ST_OLD) |-> !stamp_ch.ready)
        else $error("input ready during a pass");

endmodule : sliding_window_median

`default_nettype wire

FILE: verif/testbench.sv
// testbench: self-checking bench for sliding_window_median (running median of stamps)
// depends on swm_pkg, swm_if and the sliding_window_median rtl with its submodules
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW       = 11;
    localparam int DIRECTED_N   = 25;
    localparam int RANDOM_N     = 1030;
    // random items at the end of the run that go through with no idling on either side
    localparam int QUIET_N      = 120;
    // worst case per item is a full pass plus the longest source gap and sink stall;
    // the limit leaves a wide margin over the whole run
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic            known;   // median typed in by hand
        swm_pkg::stamp_t stamp;
        swm_pkg::stamp_t median;
    } stamp_row_t;

    // directed items, walked in order right after reset; rows with known set carry a
    // median that can be read off by hand, the others are left to the predictor
    stamp_row_t directed_rows [DIRECTED_N] = '{
        // first stamp after reset: the median is the stamp itself
        '{1'b1, 32'h0000_0000, 32'h0000_0000},
        // two held: upper middle value
        '{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
        // msb set must sort above msb clear (unsigned compare)
        '{1'b1, 32'h8000_0000, 32'h8000_0000},
        '{1'b1, 32'h7FFF_FFFF, 32'h8000_0000},
        '{1'b1, 32'h0000_0001, 32'h7FFF_FFFF},
        // equal stamps count separately
        '{1'b0, 32'h1234_5678, 32'h0},
        '{1'b0, 32'h1234_5678, 32'h0},
        '{1'b0, 32'h1234_5678, 32'h0},
        '{1'b0, 32'hAAAA_AAAA, 32'h0},
        '{1'b0, 32'h5555_5555, 32'h0},
        // window becomes full here
        '{1'b0, 32'hFFFF_FFFE, 32'h0},
        // from now on each stamp replaces the oldest one
        '{1'b0, 32'h0000_0000, 32'h0},
        '{1'b0, 32'h1234_5679, 32'h0},
        '{1'b0, 32'h1234_5677, 32'h0},
        '{1'b0, 32'hFFFF_FFFF, 32'h0},
        '{1'b0, 32'hFFFF_FFFF, 32'h0},
        '{1'b0, 32'hFFFF_FFFF, 32'h0},
        '{1'b0, 32'hFFFF_FFFF, 32'h0},
        '{1'b0, 32'hFFFF_FFFF, 32'h0},
        // six or more all-ones stamps out of eleven: median is all ones
        '{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
        '{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
        '{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
        '{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
        '{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
        // window now holds nothing but all-ones stamps
        '{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF}
    };

    logic clk;
    logic rst_n;

    swm_stamp_if  stamp_ch ();
    swm_median_if median_ch ();

    sliding_window_median #(
        .WINDOW(WINDOW)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .stamp_ch (stamp_ch),
        .median_ch(median_ch)
    );

    // idling control, set by the stimulus process phase by phase
    int unsigned src_idle_pct;
    int unsigned sink_idle_pct;
    logic        quiet_tail;

    // own copy of the window: ring of stamps, fill count and next slot to overwrite
    swm_pkg::stamp_t ring_stamps [WINDOW];
    int unsigned     ring_fill;
    int unsigned     ring_slot;

    // medians owed by the block, oldest first
    swm_pkg::stamp_t median_queue [$];

    int unsigned stamps_taken;
    int unsigned medians_seen;
    int unsigned mismatches;
    int unsigned cycles;

    // append one stamp to the window and return the median of what it then holds:
    // sorted ascending as unsigned, value at index fill/2 (upper middle when even)
    function automatic swm_pkg::stamp_t slide_in(input swm_pkg::stamp_t value);
        swm_pkg::stamp_t ordered [WINDOW];
        int unsigned     j;
        ring_stamps[ring_slot] = value;
        ring_slot = (ring_slot + 1 >= WINDOW) ? 0 : ring_slot + 1;
        if (ring_fill < WINDOW)
        begin
            ring_fill++;
        end
        for (int i = 0; i < ring_fill; i++)
        begin
            j = i;
            while (j > 0 && ordered[j-1] > ring_stamps[i])
            begin
                ordered[j] = ordered[j-1];
                j--;
            end
            ordered[j] = ring_stamps[i];
        end
        return ordered[ring_fill / 2];
    endfunction

    // length of an idle burst: none, or a random nonzero length with the given chance
    function automatic int unsigned idle_burst(input int unsigned pct);
        if (quiet_tail || $urandom_range(0, 99) >= pct)
        begin
            return 0;
        end
        return $urandom_range(1, 19);
    endfunction

    // offer one stamp and hold it until taken; then optionally idle for a burst.
    // with no burst, valid stays high into the next call, so it gets a single
    // nonblocking assignment in that time step
    task automatic offer_stamp(input swm_pkg::stamp_t value);
        int unsigned gap;
        stamp_ch.valid <= 1'b1;
        stamp_ch.stamp <= value;
        do
        begin
            @(posedge clk);
        end
        while (!stamp_ch.ready);
        gap = idle_burst(src_idle_pct);
        if (gap > 0)
        begin
            stamp_ch.valid <= 1'b0;
            // payload is junk while idle, the block must not look at it
            stamp_ch.stamp <= $urandom();
            repeat (gap) @(posedge clk);
        end
    endtask

    // free-running clock, 20 ns period
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // cycle counter and timeout guard
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d medians still owed",
                     $time, cycles, median_queue.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // result side: ready drops in random bursts
    initial
    begin : sink_side
        int unsigned hold;
        median_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            hold = idle_burst(sink_idle_pct);
            if (hold == 0)
            begin
                median_ch.ready <= 1'b1;
            end
            else
            begin
                median_ch.ready <= 1'b0;
                repeat (hold - 1) @(posedge clk);
            end
        end
    end

    // scoreboard: both handshakes are sampled at the same edge in one process,
    // results first, so a result can never be matched with the item taken
    // at that very edge
    always @(posedge clk)
    begin : scoreboard
        swm_pkg::stamp_t owed;
        if (rst_n)
        begin
            if (median_ch.valid && median_ch.ready)
            begin
                medians_seen++;
                if (median_queue.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: median %h arrived with no item outstanding",
                             $time, median_ch.median_stamp);
                end
                else
                begin
                    owed = median_queue.pop_front();
                    if (median_ch.median_stamp !== owed)
                    begin
                        mismatches++;
                        $display("%0t: median_stamp mismatch on result %0d: expected %h, actual %h",
                                 $time, medians_seen - 1, owed, median_ch.median_stamp);
                    end
                end
            end
            if (stamp_ch.valid && stamp_ch.ready)
            begin
                // the predictor always runs so its window stays in step
                owed = slide_in(stamp_ch.stamp);
                if (stamps_taken < DIRECTED_N && directed_rows[stamps_taken].known)
                begin
                    owed = directed_rows[stamps_taken].median;
                end
                median_queue.push_back(owed);
                stamps_taken++;
            end
        end
    end

    // stimulus: reset, directed table, then random stamps in phases
    initial
    begin : stimulus
        swm_pkg::stamp_t chain_clock;
        swm_pkg::stamp_t value;
        swm_pkg::stamp_t recent [$];
        int unsigned     pick;
        int unsigned     phase;

        cycles        = 0;
        stamps_taken  = 0;
        medians_seen  = 0;
        mismatches    = 0;
        ring_fill     = 0;
        ring_slot     = 0;
        quiet_tail    = 1'b0;
        src_idle_pct  = 25;
        sink_idle_pct = 25;
        chain_clock   = $urandom();

        rst_n          <= 1'b0;
        stamp_ch.valid <= 1'b0;
        stamp_ch.stamp <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        for (int i = 0; i < DIRECTED_N; i++)
        begin
            offer_stamp(directed_rows[i].stamp);
        end

        // random part; phases vary which side idles, including a stretch with no idling
        // at all, and the last items run flat out
        for (int i = 0; i < RANDOM_N; i++)
        begin
            phase = (i * 4) / (RANDOM_N - QUIET_N);
            case (phase)
                0:
                begin
                    src_idle_pct  = 30;
                    sink_idle_pct = 30;
                end
                1:
                begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 60;
                end
                2:
                begin
                    src_idle_pct  = 60;
                    sink_idle_pct = 0;
                end
                3:
                begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
                default:
                begin
                    quiet_tail = 1'b1;
                end
            endcase

            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                // chain-like: mostly rising timestamps with some jitter backwards
                chain_clock = chain_clock + $urandom_range(0, 600) - 150;
                value = chain_clock;
            end
            else if (pick < 60 && recent.size() > 0)
            begin
                // repeat a stamp still in the window
                value = recent[$urandom_range(0, recent.size() - 1)];
            end
            else if (pick < 80)
            begin
                value = $urandom();
            end
            else if (pick < 90)
            begin
                // near the ends of the range
                value = $urandom_range(0, 1) ? 32'(32'hFFFF_FFFF - $urandom_range(0, 15))
                                             : 32'($urandom_range(0, 15));
            end
            else
            begin
                // around the msb boundary
                value = 32'(32'h8000_0000 + $urandom_range(0, 31) - 16);
            end

            recent.push_back(value);
            if (recent.size() > WINDOW)
            begin
                void'(recent.pop_front());
            end
            offer_stamp(value);
        end
        stamp_ch.valid <= 1'b0;

        // wait for every owed median, then a little longer for strays
        while (median_queue.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (WINDOW + 10) @(posedge clk);

        if (median_queue.size() != 0)
        begin
            mismatches++;
            $display("%0t: %0d medians never arrived", $time, median_queue.size());
        end

        $display("%0d stamps sent (%0d from the directed table), %0d medians compared",
                 stamps_taken, DIRECTED_N, medians_seen);
        $display("%0d failures, %0d cycles", mismatches, cycles);
        if (mismatches == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule : testbench

`default_nettype wire

FILE: sim.f
sv/swm_pkg.sv
sv/swm_if.sv
sv/swm_ram.sv
sv/sliding_window_median.sv
verif/testbench.sv
